// ===== rtl/core/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types and constants of the wheel speed frame encoder: frame layout,
// speed coding constants and register indexes.
// ----------------------------------------------------------------------------
package wsfe_pkg;

   // Frame layout
   localparam int FRAME_LEN = 9;
   localparam int CNT_W     = $clog2(FRAME_LEN);

   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic [7:0]                   byte_type;
   typedef logic [FRAME_LEN-1:0][7:0]    frame_type;

   localparam cnt_type FRAME_LAST = cnt_type'(FRAME_LEN - 1);

   // Speed coding: clamp to +-144 rpm, magnitude = floor(rpm * 200 / 9).
   // The divide by 9 is a multiply by ceil(2^19 / 9) = 58255, folded with 200.
   localparam logic [7:0]  SPD_LIMIT   = 8'd144;
   localparam logic [31:0] SPD_RECIP   = 32'd11651000;
   localparam int          RECIP_SHIFT = 19;
   localparam int          CODE_W      = 12;

   typedef logic [15:0] speed_word_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 8;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_HEADER_FIRST  = csr_idx_type'(0);
   localparam csr_idx_type CSR_HEADER_SECOND = csr_idx_type'(1);

   localparam byte_type HEADER_FIRST_RST  = 8'd2;
   localparam byte_type HEADER_SECOND_RST = 8'd9;
   localparam byte_type MODE_BYTE         = 8'h00;

endpackage

// ===== rtl/core/wsfe_ifs.sv =====
// ----------------------------------------------------------------------------
// wsfe_ifs
// Channel interfaces of the wheel speed frame encoder: speed pair input,
// frame byte output and register write port.
// ----------------------------------------------------------------------------
interface wsfe_req_if;
   logic             valid;
   logic             ready;
   logic signed [8:0] speed_left;
   logic signed [8:0] speed_right;

   modport source (output valid, output speed_left, output speed_right, input ready);
   modport sink   (input valid, input speed_left, input speed_right, output ready);
endinterface

interface wsfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface wsfe_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/wsfe_csr_regs.sv =====
// ----------------------------------------------------------------------------
// wsfe_csr_regs
// Header byte registers, written through the register write channel.
// Writes to an index beyond the register list are taken and dropped.
// ----------------------------------------------------------------------------
module wsfe_csr_regs
   import wsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wsfe_csr_if.sink   csr_bus,
   output byte_type   hdr_first,
   output byte_type   hdr_second
);

   byte_type hdr_first_ff,  hdr_first_in;
   byte_type hdr_second_ff, hdr_second_in;
   logic     wr_beat;

   // Always ready: every write is taken and registered
   assign csr_bus.ready = 1'b1;
   assign wr_beat       = csr_bus.valid && csr_bus.ready;

   // Decode the register index
   always_comb begin
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      if (wr_beat) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_HEADER_FIRST:  hdr_first_in  = csr_bus.data;
            CSR_HEADER_SECOND: hdr_second_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HEADER_FIRST_RST;
         hdr_second_ff <= HEADER_SECOND_RST;
      end else begin
         hdr_first_ff  <= hdr_first_in;
         hdr_second_ff <= hdr_second_in;
      end
   end

   assign hdr_first  = hdr_first_ff;
   assign hdr_second = hdr_second_ff;

endmodule

// ===== rtl/core/wsfe_speed_code.sv =====
// ----------------------------------------------------------------------------
// wsfe_speed_code
// Turns one signed rpm value into the 16-bit sign-magnitude speed word:
// clamp to +-144, scale by 3200/144 with truncation, sign in bit 15.
// ----------------------------------------------------------------------------
module wsfe_speed_code
   import wsfe_pkg::*;
(
   input  logic signed [8:0] speed,
   output speed_word_type    word
);

   logic              neg;
   logic [8:0]        mag_raw;
   logic [7:0]        mag_sat;
   logic [31:0]       prod;
   logic [CODE_W-1:0] code;

   // Take the magnitude; -256 comes out as 256 in nine unsigned bits
   assign neg     = speed[8];
   assign mag_raw = neg ? 9'(-speed) : 9'(speed);

   // Saturate at the speed limit
   assign mag_sat = (mag_raw > 9'(SPD_LIMIT)) ? SPD_LIMIT : mag_raw[7:0];

   // Scale by multiply with the folded reciprocal, exact over 0..144
   assign prod = 32'(mag_sat) * SPD_RECIP;
   assign code = prod[RECIP_SHIFT +: CODE_W];

   assign word = {neg, 3'b000, code};

endmodule

// ===== rtl/core/wsfe_frame_build.sv =====
// ----------------------------------------------------------------------------
// wsfe_frame_build
// Input register for the speed pair and the logic that assembles the nine
// frame bytes, checksum included, for hand-off to the serializer.
// ----------------------------------------------------------------------------
module wsfe_frame_build
   import wsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wsfe_req_if.sink   req_bus,
   input  byte_type   hdr_first,
   input  byte_type   hdr_second,
   output frame_type  frame,
   output logic       frame_valid,
   input  logic       frame_ready
);

   logic              in_vld_ff, in_vld_in;
   logic signed [8:0] spd_l_ff, spd_l_in;
   logic signed [8:0] spd_r_ff, spd_r_in;
   logic              req_beat;
   speed_word_type    word_l, word_r;
   byte_type          csum;

   // Take a new beat when the register is empty or drains this cycle
   assign req_bus.ready = !in_vld_ff || frame_ready;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      spd_l_in  = spd_l_ff;
      spd_r_in  = spd_r_ff;
      if (req_beat) begin
         in_vld_in = 1'b1;
         spd_l_in  = req_bus.speed_left;
         spd_r_in  = req_bus.speed_right;
      end else if (frame_ready) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      spd_l_ff <= spd_l_in;
      spd_r_ff <= spd_r_in;
   end

   // Code both motor speeds
   wsfe_speed_code u_code_l (
      .speed (spd_l_ff),
      .word  (word_l)
   );

   wsfe_speed_code u_code_r (
      .speed (spd_r_ff),
      .word  (word_r)
   );

   // Checksum over the first eight bytes, modulo 256
   assign csum = hdr_first + hdr_second + word_l[15:8] + word_l[7:0]
               + word_r[15:8] + word_r[7:0] + MODE_BYTE + MODE_BYTE;

   // Byte 0 goes out first
   always_comb begin
      frame[0] = hdr_first;
      frame[1] = hdr_second;
      frame[2] = word_l[15:8];
      frame[3] = word_l[7:0];
      frame[4] = word_r[15:8];
      frame[5] = word_r[7:0];
      frame[6] = MODE_BYTE;
      frame[7] = MODE_BYTE;
      frame[8] = csum;
   end

   assign frame_valid = in_vld_ff;

   // A held speed pair stays put until the serializer takes it
   a_hold_pair: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !frame_ready) |=> (in_vld_ff && $stable(spd_l_ff) && $stable(spd_r_ff)))
      else $error("speed pair changed while waiting for the serializer");

endmodule

// ===== rtl/core/wsfe_frame_serial.sv =====
// ----------------------------------------------------------------------------
// wsfe_frame_serial
// Frame register that shifts the nine bytes out one beat at a time and
// flags the checksum byte as the end of the frame.
// ----------------------------------------------------------------------------
module wsfe_frame_serial
   import wsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  frame_type  frame,
   input  logic       frame_valid,
   output logic       frame_ready,
   wsfe_rsp_if.source rsp_bus
);

   logic      frm_vld_ff, frm_vld_in;
   frame_type frm_ff, frm_in;
   cnt_type   cnt_ff, cnt_in;
   logic      rsp_beat;
   logic      last_beat;

   assign rsp_beat  = rsp_bus.valid && rsp_bus.ready;
   assign last_beat = rsp_beat && (cnt_ff == FRAME_LAST);

   // Load a new frame when empty or when the checksum byte leaves
   assign frame_ready = !frm_vld_ff || last_beat;

   always_comb begin
      frm_vld_in = frm_vld_ff;
      frm_in     = frm_ff;
      cnt_in     = cnt_ff;
      if (frame_ready) begin
         frm_vld_in = frame_valid;
         frm_in     = frame;
         cnt_in     = '0;
      end else if (rsp_beat) begin
         frm_in     = frm_ff >> 8;
         cnt_in     = cnt_ff + cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         frm_vld_ff <= frm_vld_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_ff <= frm_in;
   end

   assign rsp_bus.valid      = frm_vld_ff;
   assign rsp_bus.frame_byte = frm_ff[0];
   assign rsp_bus.frame_end  = (cnt_ff == FRAME_LAST);

   // Byte count never runs past the checksum byte
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      frm_vld_ff |-> (cnt_ff <= FRAME_LAST))
      else $error("byte count beyond frame length");

   // After the end byte is taken the next frame starts at byte 0
   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.frame_end) |=> (cnt_ff == '0))
      else $error("frame did not restart after end byte");

   // An empty frame register sits at byte 0
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !frm_vld_ff |-> (cnt_ff == '0))
      else $error("byte count nonzero with no frame");

endmodule

// ===== rtl/core/wheel_speed_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_frame_encoder_unit
// Turns a pair of signed wheel speeds into a nine-byte speed frame.
// ----------------------------------------------------------------------------
// Each accepted speed pair (rpm, clamped to +-144) yields nine frame bytes on
// the result channel, one per beat: two header bytes, motor 1 word high/low,
// motor 2 word high/low, two zero mode bytes and an 8-bit sum checksum, which
// carries frame_end. The frame register sends one byte per cycle while the result
// channel is ready; a pair passes the input register and then the frame register
// before its first byte is on the result channel. The next pair is taken while
// the current frame is still going out, so frames follow each other with no gap.
// Header bytes are written through the register channel, one write per cycle;
// the user must write them only while no frame is in flight, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module wheel_speed_frame_encoder_unit
   import wsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wsfe_req_if.sink   req_bus,
   wsfe_rsp_if.source rsp_bus,
   wsfe_csr_if.sink   csr_bus
);

   byte_type  hdr_first;
   byte_type  hdr_second;
   frame_type frame;
   logic      frame_valid;
   logic      frame_ready;

   // Header registers
   wsfe_csr_regs u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .hdr_first  (hdr_first),
      .hdr_second (hdr_second)
   );

   // Input register and frame assembly
   wsfe_frame_build u_build (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .hdr_first   (hdr_first),
      .hdr_second  (hdr_second),
      .frame       (frame),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready)
   );

   // Byte serializer
   wsfe_frame_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .frame       (frame),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule

// ===== tb/tb_wheel_speed_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_wheel_speed_frame_encoder_unit
// Self-checking bench for the wheel speed frame encoder. Speed pairs go in on
// the request channel. Each accepted pair queues the nine frame bytes that a
// local encoder computes from the current header bytes. Every result beat is
// compared with the oldest queued byte. Header registers are rewritten
// between phases while no frame is in flight. Both channels stall in random
// bursts, except in the closing back-to-back phase.
// ----------------------------------------------------------------------------
module tb_wheel_speed_frame_encoder_unit;
   import wsfe_pkg::*;

   // Index outside the register list: the write must be dropped
   localparam csr_idx_type CSR_IDX_SPARE = csr_idx_type'(8'hC5);
   localparam int          DRAIN_TAIL    = 6;
   localparam int          SPEED_CEIL    = 144;
   localparam int          RAW_FULL      = 3200;
   localparam int          SIGN_WEIGHT   = 32768;

   typedef struct packed {
      byte_type data;
      logic     last;
   } frame_beat_type;

   logic clock;
   logic reset;
   logic quiet;
   int   rsp_stall;
   int   error_count;

   // Expected frame bytes, oldest first
   frame_beat_type frame_beats_q[$];

   // Local copy of the header registers
   byte_type hdr_first;
   byte_type hdr_second;

   wsfe_req_if req_if ();
   wsfe_rsp_if rsp_if ();
   wsfe_csr_if csr_if ();

   wheel_speed_frame_encoder_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Clock: 12 time units
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Sign-magnitude speed word: clamp, scale, set bit 15 when negative
   function automatic speed_word_type encode_speed(logic signed [8:0] rpm);
      int value;
      int mag;
      value = rpm;
      mag   = (value < 0) ? -value : value;
      if (mag > SPEED_CEIL) begin
         mag = SPEED_CEIL;
      end
      mag = (mag * RAW_FULL) / SPEED_CEIL;
      if (value < 0) begin
         return speed_word_type'(SIGN_WEIGHT + mag);
      end
      return speed_word_type'(mag);
   endfunction

   // Queue the nine bytes of the frame for one speed pair
   task automatic queue_frame(input logic signed [8:0] left, input logic signed [8:0] right);
      speed_word_type w_left;
      speed_word_type w_right;
      byte_type       bytes [FRAME_LEN];
      byte_type       sum;
      w_left   = encode_speed(left);
      w_right  = encode_speed(right);
      bytes[0] = hdr_first;
      bytes[1] = hdr_second;
      bytes[2] = w_left[15:8];
      bytes[3] = w_left[7:0];
      bytes[4] = w_right[15:8];
      bytes[5] = w_right[7:0];
      bytes[6] = MODE_BYTE;
      bytes[7] = MODE_BYTE;
      sum      = '0;
      for (int k = 0; k < FRAME_LEN - 1; k++) begin
         sum = sum + bytes[k];
      end
      bytes[FRAME_LEN-1] = sum;
      for (int k = 0; k < FRAME_LEN; k++) begin
         frame_beats_q.push_back('{data: bytes[k], last: (k == FRAME_LEN - 1)});
      end
   endtask

   // Send one speed pair; hold valid until the beat is taken
   task automatic send_pair(input logic signed [8:0] left, input logic signed [8:0] right);
      req_if.valid       <= 1'b1;
      req_if.speed_left  <= left;
      req_if.speed_right <= right;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      queue_frame(left, right);
      // Random idle burst on the sending side
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Lower valid and wait until every queued byte has come out
   task automatic drain_frames();
      req_if.valid <= 1'b0;
      while (frame_beats_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Write one register; keep valid up when another write follows
   task automatic write_register(input csr_idx_type idx, input byte_type data,
                                 input bit more);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      case (idx)
         CSR_HEADER_FIRST:  hdr_first  = data;
         CSR_HEADER_SECOND: hdr_second = data;
         default: ;
      endcase
      if (!more) begin
         csr_if.valid <= 1'b0;
      end
   endtask

   // Mostly in-range speeds, with extremes and the full 9-bit range mixed in
   function automatic logic signed [8:0] pick_speed();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 9'($urandom_range(0, 511));
      end
      if (sel == 1) begin
         case ($urandom_range(0, 2))
            0:       return 9'sd144;
            1:       return -9'sd144;
            default: return 9'sd0;
         endcase
      end
      return 9'($urandom_range(0, 2 * SPEED_CEIL) - SPEED_CEIL);
   endfunction

   // Result side: ready drops in random bursts
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall     <= rsp_stall - 1;
         rsp_if.ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall     <= $urandom_range(0, 10);
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready  <= 1'b1;
      end
   end

   // Compare each result beat with the oldest expected byte
   always @(posedge clock) begin
      frame_beat_type exp_beat;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frame_beats_q.size() == 0) begin
            $display("%0t: unexpected frame beat, expected none, actual byte %0d end %0b",
                     $time, rsp_if.frame_byte, rsp_if.frame_end);
            error_count++;
         end else begin
            exp_beat = frame_beats_q.pop_front();
            if (rsp_if.frame_byte !== exp_beat.data) begin
               $display("%0t: frame_byte mismatch, expected %0d, actual %0d",
                        $time, exp_beat.data, rsp_if.frame_byte);
               error_count++;
            end
            if (rsp_if.frame_end !== exp_beat.last) begin
               $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                        $time, exp_beat.last, rsp_if.frame_end);
               error_count++;
            end
         end
      end
   end

   // Reset header values, zero speed, both limits and the clamp
   task automatic test_speed_extremes();
      send_pair(9'sd0, 9'sd0);
      send_pair(9'sd144, -9'sd144);
      send_pair(-9'sd144, 9'sd144);
      send_pair(9'sd145, -9'sd145);
      send_pair(9'sd255, -9'sd256);
      send_pair(-9'sd256, 9'sd255);
      send_pair(9'sd1, -9'sd1);
      send_pair(9'sd9, -9'sd9);
      send_pair(9'sd143, -9'sd143);
      send_pair(-9'sd1, 9'sd0);
      drain_frames();
   endtask

   // Header bytes at both extremes, and a write to an index off the list
   task automatic test_header_registers();
      write_register(CSR_HEADER_FIRST, 8'h00, 1'b1);
      write_register(CSR_HEADER_SECOND, 8'hFF, 1'b0);
      send_pair(9'sd144, 9'sd72);
      send_pair(-9'sd100, 9'sd0);
      drain_frames();
      write_register(CSR_HEADER_FIRST, 8'hFF, 1'b1);
      write_register(CSR_HEADER_SECOND, 8'h00, 1'b1);
      write_register(CSR_IDX_SPARE, 8'hA5, 1'b0);
      send_pair(-9'sd144, -9'sd144);
      send_pair(9'sd144, 9'sd144);
      send_pair(9'sd37, -9'sd58);
      drain_frames();
   endtask

   // Random pairs under several header settings, with a full drain now and then
   task automatic test_random_pairs(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_register(CSR_HEADER_FIRST, byte_type'($urandom_range(0, 255)), 1'b1);
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_IDX_SPARE, byte_type'($urandom_range(0, 255)), 1'b1);
         end
         write_register(CSR_HEADER_SECOND, byte_type'($urandom_range(0, 255)), 1'b0);
         for (int i = 0; i < per_phase; i++) begin
            send_pair(pick_speed(), pick_speed());
            // Hold off until every queued byte is out
            if ($urandom_range(0, 19) == 0) begin
               drain_frames();
            end
         end
         drain_frames();
      end
   endtask

   // Closing phase: no stalls on either side, frames back to back
   task automatic test_back_to_back(input int count);
      quiet <= 1'b1;
      write_register(CSR_HEADER_FIRST, 8'hAA, 1'b1);
      write_register(CSR_HEADER_SECOND, 8'h55, 1'b0);
      for (int i = 0; i < count; i++) begin
         send_pair(pick_speed(), pick_speed());
      end
      drain_frames();
   endtask

   initial begin
      reset              = 1'b1;
      quiet              = 1'b0;
      rsp_stall          = 0;
      error_count        = 0;
      hdr_first          = HEADER_FIRST_RST;
      hdr_second         = HEADER_SECOND_RST;
      req_if.valid       = 1'b0;
      req_if.speed_left  = '0;
      req_if.speed_right = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_speed_extremes();
      test_header_registers();
      test_random_pairs(4, 55);
      test_back_to_back(40);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
